### rtl/tid_pkg.sv
// shared types, codes and constants for the timer and interrupt dispatch block
`timescale 1ns / 1ps
`default_nettype none

package tid_pkg;

  // widths of the fields
  localparam int unsigned TickW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FlagW   = 5;
  localparam int unsigned VectorW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // item kinds carried in the mode field
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_SERVICE = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMER_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLOCK_SELECT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMER_MODULO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IRQ_ENABLE   = 2'd3;

  // clock select codes
  localparam logic [1:0] CLK_SEL_1024 = 2'd0;
  localparam logic [1:0] CLK_SEL_16   = 2'd1;
  localparam logic [1:0] CLK_SEL_64   = 2'd2;
  localparam logic [1:0] CLK_SEL_256  = 2'd3;

  // request flag bit positions
  localparam int unsigned FLAG_VBLANK = 0;
  localparam int unsigned FLAG_LCD    = 1;
  localparam int unsigned FLAG_TIMER  = 2;
  localparam int unsigned FLAG_JOYPAD = 4;

  // dispatch vectors
  localparam logic [VectorW-1:0] VEC_NONE   = 7'h00;
  localparam logic [VectorW-1:0] VEC_VBLANK = 7'h40;
  localparam logic [VectorW-1:0] VEC_LCD    = 7'h48;
  localparam logic [VectorW-1:0] VEC_TIMER  = 7'h50;
  localparam logic [VectorW-1:0] VEC_JOYPAD = 7'h60;

  // configuration register set
  typedef struct packed {
    logic               timer_enable;
    logic [1:0]         clock_select;
    logic [ByteW-1:0]   timer_modulo;
    logic [FlagW-1:0]   irq_enable;
  } cfg_t;

  // one input word held in the input stage
  typedef struct packed {
    logic mode;
    logic vblank_request;
    logic lcd_request;
    logic joypad_request;
    logic master_enable;
  } item_t;

  // counter unit results towards the top and the interrupt unit
  typedef struct packed {
    logic [ByteW-1:0] divider;
    logic [ByteW-1:0] timer;
    logic             timer_ovf;
  } cnt_res_t;

  // interrupt unit results
  typedef struct packed {
    logic [FlagW-1:0]   flags;
    logic               take;
    logic [VectorW-1:0] vector;
    logic               wake;
  } irq_res_t;

endpackage

`default_nettype wire

### rtl/tid_if.sv
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
`default_nettype none

interface tid_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic vblank_request;
  logic lcd_request;
  logic joypad_request;
  logic master_enable;

  modport source (
    output valid, mode, vblank_request, lcd_request, joypad_request, master_enable,
    input  ready
  );
  modport sink (
    input  valid, mode, vblank_request, lcd_request, joypad_request, master_enable,
    output ready
  );
endinterface

interface tid_out_if;
  logic                            valid;
  logic                            ready;
  logic [tid_pkg::ByteW-1:0]       divider_value;
  logic [tid_pkg::ByteW-1:0]       timer_value;
  logic [tid_pkg::FlagW-1:0]       pending_flags;
  logic                            take_interrupt;
  logic [tid_pkg::VectorW-1:0]     vector_address;
  logic                            halt_wake;

  modport source (
    output valid, divider_value, timer_value, pending_flags, take_interrupt,
           vector_address, halt_wake,
    input  ready
  );
  modport sink (
    input  valid, divider_value, timer_value, pending_flags, take_interrupt,
           vector_address, halt_wake,
    output ready
  );
endinterface

`default_nettype wire

### rtl/tid_counter.sv
// tick counter, divider and timer counter with modulo reload
`timescale 1ns / 1ps
`default_nettype none

module tid_counter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_i,
  input  wire tid_pkg::cfg_t     cfg_i,
  output tid_pkg::cnt_res_t      res_o
);

  logic [tid_pkg::TickW-1:0] tick_q, tick_d;
  logic [tid_pkg::ByteW-1:0] div_q, div_d;
  logic [tid_pkg::ByteW-1:0] tmr_q, tmr_d, tmr_inc;
  logic                      period_hit;
  logic                      ovf;

  // period decode on the advanced tick count
  always_comb begin
    case (cfg_i.clock_select)
      tid_pkg::CLK_SEL_1024: period_hit = (tick_d == '0);
      tid_pkg::CLK_SEL_16:   period_hit = (tick_d[3:0] == '0);
      tid_pkg::CLK_SEL_64:   period_hit = (tick_d[5:0] == '0);
      default:               period_hit = (tick_d[7:0] == '0);
    endcase
  end

  // next counter values for this word
  always_comb begin
    tick_d  = tick_q;
    div_d   = div_q;
    tmr_d   = tmr_q;
    ovf     = 1'b0;
    tmr_inc = tmr_q + tid_pkg::ByteW'(1);
    if (tick_i) begin
      tick_d = tick_q + tid_pkg::TickW'(1);
    end
    if (tick_i && (tick_d[7:0] == '0)) begin
      div_d = div_q + tid_pkg::ByteW'(1);
    end
    if (tick_i && cfg_i.timer_enable && period_hit) begin
      if (tmr_inc == '0) begin
        tmr_d = cfg_i.timer_modulo;
        ovf   = 1'b1;
      end else begin
        tmr_d = tmr_inc;
      end
    end
  end

  // counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      div_q  <= '0;
      tmr_q  <= '0;
    end else begin
      tick_q <= tick_d;
      div_q  <= div_d;
      tmr_q  <= tmr_d;
    end
  end

  assign res_o.divider   = div_d;
  assign res_o.timer     = tmr_d;
  assign res_o.timer_ovf = ovf;

endmodule

`default_nettype wire

### rtl/tid_irq.sv
// interrupt request flags, priority dispatch and halt wake
`timescale 1ns / 1ps
`default_nettype none

module tid_irq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire tid_pkg::item_t             item_i,
  input  wire logic [tid_pkg::FlagW-1:0]  irq_enable_i,
  input  wire logic                       timer_ovf_i,
  output tid_pkg::irq_res_t               res_o
);

  logic [tid_pkg::FlagW-1:0]   flags_q, flags_d;
  logic [tid_pkg::FlagW-1:0]   raised;
  logic [tid_pkg::FlagW-1:0]   live;
  logic [tid_pkg::FlagW-1:0]   clear;
  logic                        take;
  logic [tid_pkg::VectorW-1:0] vector;
  logic                        wake;

  // requests raised by a tick word
  always_comb begin
    raised = '0;
    raised[tid_pkg::FLAG_VBLANK] = item_i.vblank_request;
    raised[tid_pkg::FLAG_LCD]    = item_i.lcd_request;
    raised[tid_pkg::FLAG_TIMER]  = timer_ovf_i;
    raised[tid_pkg::FLAG_JOYPAD] = item_i.joypad_request;
  end

  assign live = flags_q & irq_enable_i;

  // fixed priority pick: vblank, lcd, timer, joypad
  always_comb begin
    clear  = '0;
    take   = 1'b0;
    vector = tid_pkg::VEC_NONE;
    if (item_i.master_enable) begin
      if (live[tid_pkg::FLAG_VBLANK]) begin
        take = 1'b1;
        vector = tid_pkg::VEC_VBLANK;
        clear[tid_pkg::FLAG_VBLANK] = 1'b1;
      end else if (live[tid_pkg::FLAG_LCD]) begin
        take = 1'b1;
        vector = tid_pkg::VEC_LCD;
        clear[tid_pkg::FLAG_LCD] = 1'b1;
      end else if (live[tid_pkg::FLAG_TIMER]) begin
        take = 1'b1;
        vector = tid_pkg::VEC_TIMER;
        clear[tid_pkg::FLAG_TIMER] = 1'b1;
      end else if (live[tid_pkg::FLAG_JOYPAD]) begin
        take = 1'b1;
        vector = tid_pkg::VEC_JOYPAD;
        clear[tid_pkg::FLAG_JOYPAD] = 1'b1;
      end
    end
  end

  // next flags and result for the word in hand
  always_comb begin
    flags_d    = flags_q;
    res_o.take   = 1'b0;
    res_o.vector = tid_pkg::VEC_NONE;
    wake       = 1'b0;
    if (item_i.mode == tid_pkg::MODE_TICK) begin
      flags_d = flags_q | raised;
      wake    = |(flags_d & irq_enable_i);
    end else begin
      flags_d      = flags_q & ~clear;
      wake         = |live;
      res_o.take   = take;
      res_o.vector = vector;
    end
    res_o.flags = flags_d;
    res_o.wake  = wake;
  end

  // pending flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (advance_i) begin
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

### rtl/timer_and_interrupt_dispatch_core.sv
// top level: config registers, input stage, counter and interrupt units, result register
//
//  channel | dir | handshake        | payload
//  in_if   | in  | valid / ready    | mode, vblank/lcd/joypad request, master_enable
//  out_if  | out | valid / ready    | divider, timer, flags, take, vector, halt_wake
//  cfg     | in  | cfg_we_i         | cfg_idx_i, cfg_wdata_i
//
// one word per cycle sustained while out_if does not stall; a word passes through
// the input register and then the result register
// the counter and flag state update as a word leaves the input register
// asynchronous active-low reset clears config, counter and flag state and the valid bits
// a stall on out_if holds the result and, once the input register is full,
// drops in_if.ready
`timescale 1ns / 1ps
`default_nettype none

module timer_and_interrupt_dispatch_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tid_in_if.sink                              in_if,
  tid_out_if.source                           out_if,
  input  wire logic                           cfg_we_i,
  input  wire logic [tid_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tid_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  tid_pkg::cfg_t     cfg_q;
  tid_pkg::item_t    item_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;
  tid_pkg::cnt_res_t cnt_res;
  tid_pkg::irq_res_t irq_res;

  logic [tid_pkg::ByteW-1:0]   div_q;
  logic [tid_pkg::ByteW-1:0]   tmr_q;
  logic [tid_pkg::FlagW-1:0]   flags_q;
  logic                        take_q;
  logic [tid_pkg::VectorW-1:0] vector_q;
  logic                        wake_q;

  // handshake
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign in_take     = in_if.valid && in_if.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tid_pkg::CFG_TIMER_ENABLE: cfg_q.timer_enable <= cfg_wdata_i[0];
        tid_pkg::CFG_CLOCK_SELECT: cfg_q.clock_select <= cfg_wdata_i[1:0];
        tid_pkg::CFG_TIMER_MODULO: cfg_q.timer_modulo <= cfg_wdata_i;
        tid_pkg::CFG_IRQ_ENABLE:   cfg_q.irq_enable   <= cfg_wdata_i[tid_pkg::FlagW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode           <= in_if.mode;
      item_q.vblank_request <= in_if.vblank_request;
      item_q.lcd_request    <= in_if.lcd_request;
      item_q.joypad_request <= in_if.joypad_request;
      item_q.master_enable  <= in_if.master_enable;
    end
  end

  // counters
  tid_counter u_counter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (advance && (item_q.mode == tid_pkg::MODE_TICK)),
    .cfg_i  (cfg_q),
    .res_o  (cnt_res)
  );

  // request flags and dispatch
  tid_irq u_irq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (item_q),
    .irq_enable_i (cfg_q.irq_enable),
    .timer_ovf_i  (cnt_res.timer_ovf),
    .res_o        (irq_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      div_q    <= cnt_res.divider;
      tmr_q    <= cnt_res.timer;
      flags_q  <= irq_res.flags;
      take_q   <= irq_res.take;
      vector_q <= irq_res.vector;
      wake_q   <= irq_res.wake;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.divider_value  = div_q;
  assign out_if.timer_value    = tmr_q;
  assign out_if.pending_flags  = flags_q;
  assign out_if.take_interrupt = take_q;
  assign out_if.vector_address = vector_q;
  assign out_if.halt_wake      = wake_q;

endmodule

`default_nettype wire

### rtl/tid_checker.sv
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tid_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tid_pkg::FlagW-1:0]     out_flags,
  input wire logic                          out_take,
  input wire logic [tid_pkg::VectorW-1:0]   out_vector,
  input wire logic                          out_wake
);

  // a dispatch always carries one of the four vectors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_take) |-> (out_vector == tid_pkg::VEC_VBLANK ||
      out_vector == tid_pkg::VEC_LCD || out_vector == tid_pkg::VEC_TIMER ||
      out_vector == tid_pkg::VEC_JOYPAD))
    else $error("dispatch without a valid vector");

  // no dispatch means a zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_take) |-> (out_vector == tid_pkg::VEC_NONE))
    else $error("vector given without dispatch");

  // a dispatch needs an enabled pending request, so wake is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_take) |-> out_wake)
    else $error("dispatch without halt wake");

  // serial flag is never raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !out_flags[3])
    else $error("serial flag set");

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_vector) && $stable(out_flags)))
    else $error("stalled result changed");

endmodule

bind timer_and_interrupt_dispatch_core tid_checker u_tid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_flags  (out_if.pending_flags),
  .out_take   (out_if.take_interrupt),
  .out_vector (out_if.vector_address),
  .out_wake   (out_if.halt_wake)
);

`default_nettype wire

### tb/tb_timer_and_interrupt_dispatch_core.sv
// testbench for the timer and interrupt dispatch core: random and directed words, self-checking
`timescale 1ns / 1ps

module tb_timer_and_interrupt_dispatch_core;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 100;

  // one result word as it leaves the block
  typedef struct packed {
    logic [tid_pkg::ByteW-1:0]   divider_value;
    logic [tid_pkg::ByteW-1:0]   timer_value;
    logic [tid_pkg::FlagW-1:0]   pending_flags;
    logic                        take_interrupt;
    logic [tid_pkg::VectorW-1:0] vector_address;
    logic                        halt_wake;
  } res_word_t;

  // timer and interrupt predictor with a queue of expected result words
  class tid_scoreboard;
    logic                      timer_en  = 1'b0;
    logic [1:0]                clk_sel   = tid_pkg::CLK_SEL_1024;
    logic [tid_pkg::ByteW-1:0] modulo    = '0;
    logic [tid_pkg::FlagW-1:0] irq_mask  = '0;
    logic [tid_pkg::TickW-1:0] ticks     = '0;
    logic [tid_pkg::ByteW-1:0] divider   = '0;
    logic [tid_pkg::ByteW-1:0] timer     = '0;
    logic [tid_pkg::FlagW-1:0] flags     = '0;
    res_word_t                 expected_q[$];
    int unsigned               errors    = 0;
    int unsigned               n_words   = 0;
    int unsigned               n_checked = 0;
    int unsigned               n_dispatch = 0;
    int unsigned               n_wrap    = 0;

    function void set_config(logic [tid_pkg::CfgIdxW-1:0] idx,
                             logic [tid_pkg::CfgDataW-1:0] data);
      case (idx)
        tid_pkg::CFG_TIMER_ENABLE: timer_en = data[0];
        tid_pkg::CFG_CLOCK_SELECT: clk_sel  = data[1:0];
        tid_pkg::CFG_TIMER_MODULO: modulo   = data[tid_pkg::ByteW-1:0];
        tid_pkg::CFG_IRQ_ENABLE:   irq_mask = data[tid_pkg::FlagW-1:0];
        default: ;
      endcase
    endfunction

    function logic period_hit();
      case (clk_sel)
        tid_pkg::CLK_SEL_1024: return ticks[9:0] == '0;
        tid_pkg::CLK_SEL_16:   return ticks[3:0] == '0;
        tid_pkg::CLK_SEL_64:   return ticks[5:0] == '0;
        default:               return ticks[7:0] == '0;
      endcase
    endfunction

    // work out the result for one accepted input word
    function void note_input(tid_pkg::item_t w);
      res_word_t                 r;
      logic [tid_pkg::FlagW-1:0] live;
      r = '0;
      n_words++;
      if (w.mode == tid_pkg::MODE_TICK) begin
        ticks = ticks + 1'b1;
        if (ticks[7:0] == '0) divider = divider + 1'b1;
        if (timer_en && period_hit()) begin
          timer = timer + 1'b1;
          // wrap from 255: reload and raise the timer request
          if (timer == '0) begin
            timer = modulo;
            flags[tid_pkg::FLAG_TIMER] = 1'b1;
            n_wrap++;
          end
        end
        if (w.vblank_request) flags[tid_pkg::FLAG_VBLANK] = 1'b1;
        if (w.lcd_request)    flags[tid_pkg::FLAG_LCD]    = 1'b1;
        if (w.joypad_request) flags[tid_pkg::FLAG_JOYPAD] = 1'b1;
        r.halt_wake = |(flags & irq_mask);
        r.vector_address = tid_pkg::VEC_NONE;
      end else begin
        // wake reflects the flags before the dispatch clears one
        live = flags & irq_mask;
        r.halt_wake = |live;
        r.vector_address = tid_pkg::VEC_NONE;
        if (w.master_enable) begin
          if (live[tid_pkg::FLAG_VBLANK]) begin
            r.take_interrupt = 1'b1;
            r.vector_address = tid_pkg::VEC_VBLANK;
            flags[tid_pkg::FLAG_VBLANK] = 1'b0;
          end else if (live[tid_pkg::FLAG_LCD]) begin
            r.take_interrupt = 1'b1;
            r.vector_address = tid_pkg::VEC_LCD;
            flags[tid_pkg::FLAG_LCD] = 1'b0;
          end else if (live[tid_pkg::FLAG_TIMER]) begin
            r.take_interrupt = 1'b1;
            r.vector_address = tid_pkg::VEC_TIMER;
            flags[tid_pkg::FLAG_TIMER] = 1'b0;
          end else if (live[tid_pkg::FLAG_JOYPAD]) begin
            r.take_interrupt = 1'b1;
            r.vector_address = tid_pkg::VEC_JOYPAD;
            flags[tid_pkg::FLAG_JOYPAD] = 1'b0;
          end
        end
        if (r.take_interrupt) n_dispatch++;
      end
      r.divider_value = divider;
      r.timer_value   = timer;
      r.pending_flags = flags;
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(res_word_t got);
      res_word_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none, actual %h", $time, got);
        return;
      end
      exp_w = expected_q.pop_front();
      n_checked++;
      compare_field("divider_value", exp_w.divider_value, got.divider_value);
      compare_field("timer_value", exp_w.timer_value, got.timer_value);
      compare_field("pending_flags", exp_w.pending_flags, got.pending_flags);
      compare_field("take_interrupt", exp_w.take_interrupt, got.take_interrupt);
      compare_field("vector_address", exp_w.vector_address, got.vector_address);
      compare_field("halt_wake", exp_w.halt_wake, got.halt_wake);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tid_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tid_pkg::CfgDataW-1:0] cfg_wdata_i;

  tid_in_if  in_if ();
  tid_out_if out_if ();

  tid_scoreboard sb = new();

  int unsigned tx_count = 0;
  bit          tx_calm  = 1'b0;

  timer_and_interrupt_dispatch_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t timeout with %0d words outstanding", $time, sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned cyc;
    int unsigned pick;
    bit          hold_done;
    bit          rx_calm;
    res_word_t   got;
    stall_left = 0;
    hold_left  = 0;
    cyc        = 0;
    hold_done  = 1'b0;
    rx_calm    = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (out_if.valid && out_if.ready) begin
        got.divider_value  = out_if.divider_value;
        got.timer_value    = out_if.timer_value;
        got.pending_flags  = out_if.pending_flags;
        got.take_interrupt = out_if.take_interrupt;
        got.vector_address = out_if.vector_address;
        got.halt_wake      = out_if.halt_wake;
        sb.check_result(got);
      end
      if (cyc % 200 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && sb.n_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_calm) begin
        out_if.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_if.ready <= 1'b1;
        end else if (pick < 90) begin
          stall_left = $urandom_range(0, 2);
          out_if.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(7, 39);
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  function automatic tid_pkg::item_t mk_word(logic mode, logic vb, logic lcd, logic joy,
                                             logic me);
    tid_pkg::item_t w;
    w.mode           = mode;
    w.vblank_request = vb;
    w.lcd_request    = lcd;
    w.joypad_request = joy;
    w.master_enable  = me;
    return w;
  endfunction

  // random word: mostly ticks, sparse request lines, unused fields random too
  function automatic tid_pkg::item_t rand_word(int unsigned tick_pct);
    return mk_word(($urandom_range(0, 99) < tick_pct) ? tid_pkg::MODE_TICK
                                                      : tid_pkg::MODE_SERVICE,
                   $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0,
                   $urandom_range(0, 15) == 0, $urandom_range(0, 9) < 7);
  endfunction

  // offer one input word after a random gap and wait for it to be taken
  task automatic send_word(input tid_pkg::item_t w);
    int unsigned gap;
    int unsigned pick;
    if (tx_count % 100 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    tx_count++;
    gap = 0;
    if (!tx_calm) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(8, 40);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= w.mode;
    in_if.vblank_request <= w.vblank_request;
    in_if.lcd_request    <= w.lcd_request;
    in_if.joypad_request <= w.joypad_request;
    in_if.master_enable  <= w.master_enable;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(w);
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write the whole register set while the block is idle
  task automatic write_config(logic en, logic [1:0] sel, logic [tid_pkg::ByteW-1:0] mod,
                              logic [tid_pkg::FlagW-1:0] mask);
    logic [tid_pkg::CfgDataW-1:0] vals [4];
    vals[tid_pkg::CFG_TIMER_ENABLE] = tid_pkg::CfgDataW'(en);
    vals[tid_pkg::CFG_CLOCK_SELECT] = tid_pkg::CfgDataW'(sel);
    vals[tid_pkg::CFG_TIMER_MODULO] = tid_pkg::CfgDataW'(mod);
    vals[tid_pkg::CFG_IRQ_ENABLE]   = tid_pkg::CfgDataW'(mask);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= tid_pkg::CfgIdxW'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_config(tid_pkg::CfgIdxW'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic en, logic [1:0] sel, logic [tid_pkg::ByteW-1:0] mod,
                           logic [tid_pkg::FlagW-1:0] mask, int unsigned n,
                           int unsigned tick_pct);
    write_config(en, sel, mod, mask);
    repeat (n) send_word(rand_word(tick_pct));
    drain();
  endtask

  // main sequence
  initial begin
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_wdata_i          <= '0;
    in_if.valid          <= 1'b0;
    in_if.mode           <= tid_pkg::MODE_TICK;
    in_if.vblank_request <= 1'b0;
    in_if.lcd_request    <= 1'b0;
    in_if.joypad_request <= 1'b0;
    in_if.master_enable  <= 1'b0;
    out_if.ready         <= 1'b0;
    rst_ni               <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: every request, ignored lines, priority order, no-dispatch cases
    write_config(1'b1, tid_pkg::CLK_SEL_16, 8'hFF, 5'h1F);
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_TICK,    1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_TICK,    1'b1, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(tid_pkg::MODE_TICK,    1'b0, 1'b1, 1'b0, 1'b0));
    send_word(mk_word(tid_pkg::MODE_TICK,    1'b0, 1'b0, 1'b1, 1'b0));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_TICK,    1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(tid_pkg::MODE_SERVICE, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (8) send_word(mk_word(tid_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    // tick run at period 16 with a high reload, timer request enabled
    run_phase(1'b1, tid_pkg::CLK_SEL_16, 8'hFC, 5'h04, 200, 96);
    // everything off: timer holds
    run_phase(1'b0, tid_pkg::CLK_SEL_1024, 8'h00, 5'h00, 40, 75);
    // period 1024 with all enables
    run_phase(1'b1, tid_pkg::CLK_SEL_1024, 8'hFF, 5'h1F, 90, 92);
    // period 64 with random reload and enables
    run_phase(1'b1, tid_pkg::CLK_SEL_64, 8'($urandom_range(0, 255)),
              5'($urandom_range(0, 31)), 70, 75);
    // period 256, only the serial enable set: nothing is ever dispatched
    run_phase(1'b1, tid_pkg::CLK_SEL_256, 8'h00, 5'h08, 60, 80);
    // period 16 with reload 255
    run_phase(1'b1, tid_pkg::CLK_SEL_16, 8'hFF, 5'h1F, 60, 70);
    // fully random settings
    repeat (3)
      run_phase(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 20, 70);

    repeat (10) @(posedge clk_i);
    $display("%0d words sent over ten register settings, %0d results checked",
             sb.n_words, sb.n_checked);
    $display("%0d interrupts dispatched, %0d timer wraps, %0d mismatches",
             sb.n_dispatch, sb.n_wrap, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
